// ===== src/bfpa_pkg.sv =====
// Package with the transaction types, sequencer states and constants of the partition allocator.
`timescale 1ns / 1ps
package bfpa_pkg;

   localparam int SizeWidth = 40;
   localparam int TagWidth = 16;
   localparam int ReqWidth = 24;
   localparam int PageWidth = 20;
   localparam int CountWidth = 32;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_OK = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef struct packed {
      cmd_type cmd;
      logic [TagWidth-1:0] tag;
      logic [ReqWidth-1:0] req_size;
   } req_type;

   typedef struct packed {
      logic [SizeWidth-1:0] largest_free;
      logic [CountWidth-1:0] pages_total;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic [TagWidth-1:0] tag;
      logic [SizeWidth-1:0] size;
      logic [SizeWidth-1:0] addr;
      logic free;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_LAST_RD,
      ST_LAST,
      ST_DIV,
      ST_PLAN,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_REL_RD,
      ST_REL,
      ST_MRG_RD,
      ST_MRG,
      ST_CMP,
      ST_MAX_RD,
      ST_MAX,
      ST_DONE
   } state_type;

endpackage

// ===== src/bfpa_table.sv =====
// Partition table memory with one synchronous read port and one write port.
`timescale 1ns / 1ps
module bfpa_table
   import bfpa_pkg::*;
#(
   parameter int MAX_PARTS = 64
) (
   input logic clock,
   input logic rd_en,
   input logic [$clog2(MAX_PARTS)-1:0] rd_addr,
   output entry_type rd_data,
   input logic wr_en,
   input logic [$clog2(MAX_PARTS)-1:0] wr_addr,
   input entry_type wr_data
);

   entry_type mem [MAX_PARTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/bfpa_divider.sv =====
// Radix-2 restoring divider that computes the page count for a grow request.
`timescale 1ns / 1ps
module bfpa_divider
   import bfpa_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic [SizeWidth-1:0] dividend,
   input logic [PageWidth-1:0] divisor,
   output logic busy,
   output logic [SizeWidth-1:0] quotient,
   output logic [PageWidth-1:0] remainder
);

   localparam int StepWidth = $clog2(SizeWidth + 1);

   logic [StepWidth-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic [SizeWidth-1:0] quo_ff, quo_in;
   logic [PageWidth:0] rem_ff, rem_in;
   logic [PageWidth:0] trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial = {rem_ff[PageWidth-1:0], quo_ff[SizeWidth-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = StepWidth'(SizeWidth);
         quo_in = dividend;
         rem_in = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[SizeWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SizeWidth-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepWidth'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff[PageWidth-1:0];

endmodule

// ===== src/bfpa_engine.sv =====
// Sequencer that scans, splits, releases and merges table entries for one transaction.
`timescale 1ns / 1ps
module bfpa_engine
   import bfpa_pkg::*;
#(
   parameter int MAX_PARTS = 64
) (
   input logic clock,
   input logic reset,
   input logic start,
   input req_type req,
   input logic [PageWidth-1:0] page_bytes,
   output logic done,
   output rsp_type rsp,
   output logic busy
);

   localparam int IdxWidth = $clog2(MAX_PARTS);
   localparam int CntWidth = $clog2(MAX_PARTS + 1);

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] idx_ff, idx_in;
   logic [CntWidth-1:0] wr_ff, wr_in;
   logic [CountWidth-1:0] pages_ff, pages_in;
   logic [SizeWidth-1:0] max_ff, max_in;
   logic found_ff, found_in;
   logic [IdxWidth-1:0] best_ff, best_in;
   logic [SizeWidth-1:0] best_size_ff, best_size_in;
   logic [SizeWidth-1:0] best_addr_ff, best_addr_in;
   entry_type last_ff, last_in;
   entry_type acc_ff, acc_in;
   logic [SizeWidth-1:0] grow_ff, grow_in;
   logic [SizeWidth-1:0] npages_ff, npages_in;
   logic [SizeWidth-1:0] avail_ff, avail_in;
   logic [SizeWidth-1:0] rem_ff, rem_in;
   logic append_ff, append_in;
   logic full_ff, full_in;
   logic [1:0] phase_ff, phase_in;

   logic rd_en;
   logic [IdxWidth-1:0] rd_addr;
   entry_type rd_data;
   logic wr_en;
   logic [IdxWidth-1:0] wr_addr;
   entry_type wr_data;

   logic div_start, div_busy;
   logic [SizeWidth-1:0] div_dividend, div_quo;
   logic [PageWidth-1:0] div_rem, ps_eff;
   logic [SizeWidth-1:0] need;
   logic [SizeWidth:0] slots;
   logic [SizeWidth+1:0] psum;
   logic [ReqWidth+PageWidth-1:0] grow_prod;

   bfpa_table #(.MAX_PARTS(MAX_PARTS)) u_table (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   bfpa_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(ps_eff), .busy(div_busy), .quotient(div_quo), .remainder(div_rem)
   );

   assign ps_eff = (page_bytes == '0) ? PageWidth'(1) : page_bytes;
   assign need = last_ff.free ? (SizeWidth'(req_ff.req_size) - last_ff.size)
                              : SizeWidth'(req_ff.req_size);
   assign div_dividend = need;
   assign grow_prod = npages_ff[ReqWidth-1:0] * ps_eff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = (req.cmd == CMD_FREE) ? ST_REL_RD : ST_SCAN_RD;
         ST_SCAN_RD: state_in = ST_SCAN;
         ST_SCAN: if (idx_ff == count_ff) state_in = found_in ? ST_PLAN : ST_LAST_RD;
         ST_LAST_RD: state_in = ST_LAST;
         ST_LAST: state_in = ST_DIV;
         ST_DIV: if (!div_busy && phase_ff == 2'd1) state_in = ST_PLAN;
         ST_PLAN: begin
            if (full_in) state_in = ST_MAX_RD;
            else if (rem_in != '0 && !found_ff ? 1'b0 : (rem_in != '0))
               state_in = ST_SHIFT_RD;
            else state_in = ST_WRITE;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = (idx_ff == CntWidth'(best_ff) + 1'b1) ? ST_WRITE : ST_SHIFT_RD;
         ST_WRITE: if (phase_ff == 2'd1) state_in = ST_MAX_RD;
         ST_REL_RD: state_in = ST_REL;
         ST_REL: if (idx_ff == count_ff) state_in = ST_MRG_RD;
         ST_MRG_RD: state_in = ST_MRG;
         ST_MRG: if (idx_ff == count_ff) state_in = ST_CMP;
         ST_CMP: state_in = ST_MAX_RD;
         ST_MAX_RD: state_in = ST_MAX;
         ST_MAX: if (idx_ff == count_ff) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      wr_in = wr_ff;
      pages_in = pages_ff;
      max_in = max_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_size_in = best_size_ff;
      best_addr_in = best_addr_ff;
      last_in = last_ff;
      acc_in = acc_ff;
      grow_in = grow_ff;
      npages_in = npages_ff;
      avail_in = avail_ff;
      rem_in = rem_ff;
      append_in = append_ff;
      full_in = full_ff;
      phase_in = phase_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      div_start = 1'b0;
      slots = '0;
      psum = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
               idx_in = '0;
               found_in = 1'b0;
               append_in = 1'b0;
               full_in = 1'b0;
               phase_in = '0;
               grow_in = '0;
               npages_in = '0;
            end
         end
         ST_SCAN_RD, ST_REL_RD, ST_MAX_RD, ST_LAST_RD: begin
            rd_en = 1'b1;
            rd_addr = (state_ff == ST_LAST_RD) ? IdxWidth'(count_ff - 1'b1)
                                                : IdxWidth'(idx_ff);
            if (state_ff == ST_MAX_RD) begin
               max_in = '0;
               idx_in = '0;
               rd_addr = '0;
            end
            if (state_ff == ST_SCAN_RD || state_ff == ST_REL_RD) begin
               idx_in = idx_ff + 1'b1;
               rd_addr = IdxWidth'(idx_ff);
            end
            if (state_ff == ST_MAX_RD) idx_in = CntWidth'(1);
         end
         ST_SCAN: begin
            if (rd_data.free && rd_data.size >= SizeWidth'(req_ff.req_size) &&
                (!found_ff || rd_data.size < best_size_ff)) begin
               found_in = 1'b1;
               best_in = IdxWidth'(idx_ff - 1'b1);
               best_size_in = rd_data.size;
               best_addr_in = rd_data.addr;
            end
            if (idx_ff != count_ff) begin
               rd_en = 1'b1;
               rd_addr = IdxWidth'(idx_ff);
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            last_in = rd_data;
            phase_in = '0;
         end
         ST_DIV: begin
            if (phase_ff == 2'd0) begin
               div_start = 1'b1;
               phase_in = 2'd2;
            end else if (phase_ff == 2'd2) begin
               phase_in = 2'd3;
            end else if (phase_ff == 2'd3) begin
               if (!div_busy) begin
                  npages_in = div_quo + ((div_rem != '0) ? SizeWidth'(1) : '0);
                  phase_in = 2'd1;
               end
            end else begin
               grow_in = SizeWidth'(grow_prod);
               phase_in = '0;
            end
         end
         ST_PLAN: begin
            if (found_ff) begin
               avail_in = best_size_ff;
            end else if (last_ff.free) begin
               best_in = IdxWidth'(count_ff - 1'b1);
               avail_in = last_ff.size + grow_ff;
               best_addr_in = last_ff.addr;
            end else begin
               append_in = 1'b1;
               best_in = IdxWidth'(count_ff);
               avail_in = grow_ff;
               best_addr_in = last_ff.addr + last_ff.size;
            end
            rem_in = avail_in - SizeWidth'(req_ff.req_size);
            slots = (SizeWidth+1)'(count_ff) + (SizeWidth+1)'(append_in) +
                    (SizeWidth+1)'(rem_in != '0);
            full_in = slots > (SizeWidth+1)'(MAX_PARTS);
            if (!full_in) begin
               if (!found_ff) begin
                  psum = (SizeWidth+2)'(pages_ff) + (SizeWidth+2)'(npages_ff);
                  pages_in = (psum > (SizeWidth+2)'({CountWidth{1'b1}})) ?
                             {CountWidth{1'b1}} : psum[CountWidth-1:0];
               end
               count_in = count_ff + (append_in ? 1'b1 : 1'b0) + ((rem_in != '0) ? 1'b1 : 1'b0);
               idx_in = count_ff + (append_in ? 1'b1 : 1'b0);
               phase_in = '0;
            end
         end
         ST_SHIFT_RD: begin
            rd_en = 1'b1;
            rd_addr = IdxWidth'(idx_ff - 1'b1);
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_addr = IdxWidth'(idx_ff);
            wr_data = rd_data;
            idx_in = idx_ff - 1'b1;
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (phase_ff == 2'd0) begin
               wr_addr = best_ff;
               wr_data.tag = req_ff.tag;
               wr_data.size = SizeWidth'(req_ff.req_size);
               wr_data.addr = best_addr_ff;
               wr_data.free = 1'b0;
               phase_in = 2'd1;
               wr_en = 1'b1;
            end else begin
               wr_en = (rem_ff != '0);
               wr_addr = IdxWidth'(best_ff + 1'b1);
               wr_data.tag = '0;
               wr_data.size = rem_ff;
               wr_data.addr = best_addr_ff + SizeWidth'(req_ff.req_size);
               wr_data.free = 1'b1;
            end
         end
         ST_REL: begin
            if (!rd_data.free && rd_data.tag == req_ff.tag) begin
               wr_en = 1'b1;
               wr_addr = IdxWidth'(idx_ff - 1'b1);
               wr_data = rd_data;
               wr_data.free = 1'b1;
               wr_data.tag = '0;
            end
            if (idx_ff != count_ff) begin
               rd_en = 1'b1;
               rd_addr = IdxWidth'(idx_ff);
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = '0;
               wr_in = '0;
            end
         end
         ST_MRG_RD: begin
            rd_en = 1'b1;
            rd_addr = '0;
            idx_in = CntWidth'(1);
            acc_in = '0;
            phase_in = '0;
         end
         ST_MRG: begin
            // The first entry read starts the accumulator; later free
            // neighbors fold into a free accumulator, and every closed run is written compacted.
            if (phase_ff == 2'd0) begin
               acc_in = rd_data;
               phase_in = 2'd1;
               wr_in = '0;
            end else if (acc_ff.free && rd_data.free) begin
               acc_in.size = acc_ff.size + rd_data.size;
            end else begin
               wr_en = 1'b1;
               wr_addr = IdxWidth'(wr_ff);
               wr_data = acc_ff;
               wr_in = wr_ff + 1'b1;
               acc_in = rd_data;
            end
            if (idx_ff != count_ff) begin
               rd_en = 1'b1;
               rd_addr = IdxWidth'(idx_ff);
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CMP: begin
            wr_en = 1'b1;
            wr_addr = IdxWidth'(wr_ff);
            wr_data = acc_ff;
            count_in = wr_ff + 1'b1;
         end
         ST_MAX: begin
            if (rd_data.free && rd_data.size > max_ff) max_in = rd_data.size;
            if (idx_ff != count_ff) begin
               rd_en = 1'b1;
               rd_addr = IdxWidth'(idx_ff);
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: rd_en = 1'b0;
         default: rd_en = 1'b0;
      endcase
      if (reset) begin
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data = '0;
         wr_data.free = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CntWidth'(1);
         pages_ff <= '0;
         max_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pages_ff <= pages_in;
         max_ff <= max_in;
         phase_ff <= phase_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      wr_ff <= wr_in;
      found_ff <= found_in;
      best_ff <= best_in;
      best_size_ff <= best_size_in;
      best_addr_ff <= best_addr_in;
      last_ff <= last_in;
      acc_ff <= acc_in;
      grow_ff <= grow_in;
      npages_ff <= npages_in;
      avail_ff <= avail_in;
      rem_ff <= rem_in;
      append_ff <= append_in;
      full_ff <= full_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);
   assign rsp.largest_free = max_ff;
   assign rsp.pages_total = pages_ff;
   assign rsp.status = full_ff ? STATUS_FULL : STATUS_OK;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CntWidth'(MAX_PARTS))
      else $error("partition count out of range");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("done held for more than one cycle");
   a_full_keeps_pages: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLAN && full_in) |=> $stable(pages_ff))
      else $error("pages counted on a rejected request");
`endif

endmodule

// ===== src/best_fit_partition_allocator.sv =====
// Top level of the best-fit partition allocator with its channels and page size register.
`timescale 1ns / 1ps
// The block keeps an address-ordered partition table in a synchronous
// memory with one read and one write port and serves one transaction at a
// time. A request transaction either allocates req_size bytes for a tag or
// frees every partition that carries the tag. Each request yields one
// response transaction with the largest free size, the total pages
// requested and a status that flags a full table.
// An allocation scans the table, moves each entry behind a split up by one slot
// and, when memory must grow, reads the last entry and runs the bit-serial page
// division; a free releases, merges and compacts the entries. The one read port
// paces both. The next request is accepted at the earliest in the first cycle
// that the response is valid and not stalled. req_stall is high while a request
// is in progress or the response register is full and stalled.
// Reset leaves one free partition of size zero, no pages and a page size
// of 4096. csr_write_enable writes the page size; the user must assert it only
// while the block is idle, which the block itself does not enforce.
module best_fit_partition_allocator
   import bfpa_pkg::*;
#(
   parameter int MAX_PARTS = 64
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_write_enable,
   input logic [PageWidth-1:0] csr_write_data
);

   logic [PageWidth-1:0] page_bytes_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic eng_busy, eng_done, start;
   rsp_type eng_rsp;

   assign req_stall = eng_busy || (rsp_valid_ff && rsp_stall);
   assign start = req_valid && !req_stall;

   bfpa_engine #(.MAX_PARTS(MAX_PARTS)) u_engine (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .page_bytes(page_bytes_ff), .done(eng_done), .rsp(eng_rsp), .busy(eng_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_bytes_ff <= PageWidth'(4096);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) page_bytes_ff <= csr_write_data;
         if (eng_done) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (eng_done) rsp_ff <= eng_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
